FILE: rtl/core/mrh_pkg.sv
package mrh_pkg;

  localparam int CAPACITY_DEF   = 1024;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_LOW   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_PUSH_RD,
    OP_PUSH_WR,
    OP_REF_RD,
    OP_REF_LD,
    OP_WALK,
    OP_WALK_W,
    OP_REP,
    OP_REP_S,
    OP_REP_K,
    OP_REP_B,
    OP_POP_RD,
    OP_POP_B,
    OP_POP_E
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic err;
    logic used0;
    logic walk_done;
    logic rep_done;
  } stat_t;

endpackage

FILE: rtl/core/mrh_ctrl.sv
module mrh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mrh_pkg::stat_t st,
  output mrh_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ERR, S_PUSH_RD, S_PUSH_WR, S_REF_RD, S_REF_LD, S_WALK,
    S_WALK_W, S_REP, S_REP_S, S_REP_K, S_REP_B, S_POP_RD, S_POP_B, S_POP_E
  } state_t;

  state_t state, state_next;
  logic   hold;
  logic   finish;

  assign hold     = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = mrh_pkg::OP_NONE;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = mrh_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.err) state_next = S_ERR;
        else if (!st.is_pop) state_next = S_PUSH_RD;
        else if (st.used0) state_next = S_POP_RD;
        else state_next = S_REF_RD;
      end
      S_ERR: begin
        if (!hold) begin
          cmd.op     = mrh_pkg::OP_ERR;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PUSH_RD: begin
        cmd.op     = mrh_pkg::OP_PUSH_RD;
        state_next = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        if (!hold) begin
          cmd.op     = mrh_pkg::OP_PUSH_WR;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REF_RD: begin
        cmd.op     = mrh_pkg::OP_REF_RD;
        state_next = S_REF_LD;
      end
      S_REF_LD: begin
        cmd.op     = mrh_pkg::OP_REF_LD;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (st.walk_done) state_next = S_REP;
        else begin
          cmd.op     = mrh_pkg::OP_WALK;
          state_next = S_WALK_W;
        end
      end
      S_WALK_W: begin
        cmd.op     = mrh_pkg::OP_WALK_W;
        state_next = S_WALK;
      end
      S_REP: begin
        if (st.rep_done) state_next = S_POP_RD;
        else begin
          cmd.op     = mrh_pkg::OP_REP;
          state_next = S_REP_S;
        end
      end
      S_REP_S: begin
        cmd.op     = mrh_pkg::OP_REP_S;
        state_next = S_REP_K;
      end
      S_REP_K: begin
        cmd.op     = mrh_pkg::OP_REP_K;
        state_next = S_REP_B;
      end
      S_REP_B: begin
        cmd.op     = mrh_pkg::OP_REP_B;
        state_next = S_REP;
      end
      S_POP_RD: begin
        cmd.op     = mrh_pkg::OP_POP_RD;
        state_next = S_POP_B;
      end
      S_POP_B: begin
        cmd.op     = mrh_pkg::OP_POP_B;
        state_next = S_POP_E;
      end
      S_POP_E: begin
        if (!hold) begin
          cmd.op     = mrh_pkg::OP_POP_E;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/mrh_datapath.sv
module mrh_datapath #(
  parameter int CAPACITY   = mrh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = mrh_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = mrh_pkg::VALUE_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mrh_pkg::cmd_t         cmd,
  output mrh_pkg::stat_t        st,
  input  logic                  opcode,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic [1:0]            status,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [CW-1:0]         count,
  output logic                  is_empty
);

  localparam int SW = $clog2(CAPACITY);
  localparam int NB = KEY_BITS + 1;
  localparam int BW = $clog2(NB);

  function automatic logic [BW-1:0] key_span(input logic [KEY_BITS-1:0] x);
    logic [BW-1:0] n;
    n = '0;
    for (int j = 0; j < KEY_BITS; j++) if (x[j]) n = BW'(j + 1);
    return n;
  endfunction

  logic [KEY_BITS-1:0]   ekey_mem [CAPACITY];
  logic [VALUE_BITS-1:0] eval_mem [CAPACITY];
  logic [SW-1:0]         link_mem [CAPACITY];
  logic [SW-1:0]         free_mem [CAPACITY];
  logic [SW-1:0]         scr_mem  [CAPACITY];
  logic [SW-1:0]         bhead_mem [NB];
  logic [KEY_BITS-1:0]   bmin_mem  [NB];
  logic [CW-1:0]         blen_mem  [NB];

  logic                  op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [KEY_BITS-1:0]   last_key;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         wmark;
  logic [NB-1:0]         used;
  logic [BW-1:0]         bsel;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         ptr;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         len_r;

  logic [KEY_BITS-1:0]   ekey_rd;
  logic [VALUE_BITS-1:0] eval_rd;
  logic [SW-1:0]         link_rd, free_rd, scr_rd, bhead_rd;
  logic [KEY_BITS-1:0]   bmin_rd;
  logic [CW-1:0]         blen_rd;

  logic                  e_re, l_re, f_re, s_re, b_re;
  logic [SW-1:0]         e_ra, l_ra, s_ra;
  logic [BW-1:0]         b_ra;
  logic                  e_we, l_we, f_we, s_we, b_we;
  logic [SW-1:0]         e_wa, l_wa, f_wa, s_wa, l_wd, f_wd, s_wd;
  logic [KEY_BITS-1:0]   ek_wd;
  logic [SW-1:0]         bh_wd;
  logic [KEY_BITS-1:0]   bm_wd;
  logic [CW-1:0]         bl_wd;

  logic [1:0]            code;
  logic [BW-1:0]         low_b;
  logic [CW-1:0]         pos_push, pos_pop, idx_dec, len_dec;
  logic [SW-1:0]         new_slot;
  logic [KEY_BITS-1:0]   file_min;
  logic [CW-1:0]         file_len;

  always_comb begin
    if (op_r) code = (cnt == '0) ? mrh_pkg::ST_EMPTY : mrh_pkg::ST_OK;
    else if (cnt >= CW'(CAPACITY)) code = mrh_pkg::ST_FULL;
    else if (key_r < last_key) code = mrh_pkg::ST_LOW;
    else code = mrh_pkg::ST_OK;
  end

  always_comb begin
    low_b = BW'(NB - 1);
    for (int j = NB - 1; j >= 1; j--) if (used[j]) low_b = BW'(j);
  end

  assign st.is_pop    = op_r;
  assign st.err       = (code != mrh_pkg::ST_OK);
  assign st.used0     = used[0];
  assign st.walk_done = (idx == len_r);
  assign st.rep_done  = (idx == '0);

  assign pos_push = CW'(CAPACITY - 1) - cnt;
  assign pos_pop  = CW'(CAPACITY) - cnt;
  assign idx_dec  = idx - CW'(1);
  assign len_dec  = len_r - CW'(1);
  assign new_slot = (cnt == wmark) ? pos_push[SW-1:0] : free_rd;
  assign file_min = (!used[bsel] || key_r < bmin_rd) ? key_r : bmin_rd;
  assign file_len = used[bsel] ? blen_rd + CW'(1) : CW'(1);

  always_comb begin
    e_re = 1'b0; l_re = 1'b0; f_re = 1'b0; s_re = 1'b0; b_re = 1'b0;
    e_ra = '0;   l_ra = '0;   s_ra = '0;   b_ra = '0;
    e_we = 1'b0; l_we = 1'b0; f_we = 1'b0; s_we = 1'b0; b_we = 1'b0;
    e_wa = new_slot; l_wa = slot; f_wa = pos_pop[SW-1:0]; s_wa = idx[SW-1:0];
    l_wd = bhead_rd; f_wd = slot; s_wd = ptr; ek_wd = key_r;
    bh_wd = slot; bm_wd = file_min; bl_wd = file_len;
    case (cmd.op)
      mrh_pkg::OP_PUSH_RD: begin
        f_re = 1'b1;
        b_re = 1'b1;
        b_ra = key_span(key_r ^ last_key);
      end
      mrh_pkg::OP_PUSH_WR: begin
        e_we  = 1'b1;
        l_we  = 1'b1;
        l_wa  = new_slot;
        b_we  = 1'b1;
        bh_wd = new_slot;
      end
      mrh_pkg::OP_REF_RD: begin
        b_re = 1'b1;
        b_ra = low_b;
      end
      mrh_pkg::OP_WALK: begin
        s_we = 1'b1;
        l_re = 1'b1;
        l_ra = ptr;
      end
      mrh_pkg::OP_REP: begin
        s_re = 1'b1;
        s_ra = idx_dec[SW-1:0];
      end
      mrh_pkg::OP_REP_S: begin
        e_re = 1'b1;
        e_ra = scr_rd;
      end
      mrh_pkg::OP_REP_K: begin
        b_re = 1'b1;
        b_ra = key_span(ekey_rd ^ last_key);
      end
      mrh_pkg::OP_REP_B: begin
        l_we = 1'b1;
        b_we = 1'b1;
      end
      mrh_pkg::OP_POP_RD: begin
        b_re = 1'b1;
      end
      mrh_pkg::OP_POP_B: begin
        e_re = 1'b1;
        e_ra = bhead_rd;
        l_re = 1'b1;
        l_ra = bhead_rd;
      end
      mrh_pkg::OP_POP_E: begin
        f_we  = 1'b1;
        b_we  = 1'b1;
        bh_wd = link_rd;
        bm_wd = bmin_rd;
        bl_wd = len_dec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      ekey_mem[e_wa] <= ek_wd;
      eval_mem[e_wa] <= val_r;
    end
    if (e_re) begin
      ekey_rd <= ekey_mem[e_ra];
      eval_rd <= eval_mem[e_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (l_we) link_mem[l_wa] <= l_wd;
    if (l_re) link_rd <= link_mem[l_ra];
  end

  always_ff @(posedge clk) begin
    if (f_we) free_mem[f_wa] <= f_wd;
    if (f_re) free_rd <= free_mem[pos_push[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_we) scr_mem[s_wa] <= s_wd;
    if (s_re) scr_rd <= scr_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bhead_mem[bsel] <= bh_wd;
      bmin_mem[bsel]  <= bm_wd;
      blen_mem[bsel]  <= bl_wd;
    end
    if (b_re) begin
      bhead_rd <= bhead_mem[b_ra];
      bmin_rd  <= bmin_mem[b_ra];
      blen_rd  <= blen_mem[b_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key <= '0;
      cnt      <= '0;
      wmark    <= '0;
      used     <= '0;
    end else begin
      case (cmd.op)
        mrh_pkg::OP_LOAD: begin
          op_r  <= opcode;
          key_r <= key;
          val_r <= value;
        end
        mrh_pkg::OP_ERR: begin
          status    <= code;
          out_key   <= '0;
          out_value <= '0;
          count     <= cnt;
          is_empty  <= (cnt == '0);
        end
        mrh_pkg::OP_PUSH_RD: bsel <= key_span(key_r ^ last_key);
        mrh_pkg::OP_PUSH_WR: begin
          used[bsel] <= 1'b1;
          cnt        <= cnt + CW'(1);
          if (cnt == wmark) wmark <= wmark + CW'(1);
          status    <= mrh_pkg::ST_OK;
          out_key   <= '0;
          out_value <= '0;
          count     <= cnt + CW'(1);
          is_empty  <= 1'b0;
        end
        mrh_pkg::OP_REF_RD: bsel <= low_b;
        mrh_pkg::OP_REF_LD: begin
          last_key   <= bmin_rd;
          used[bsel] <= 1'b0;
          ptr        <= bhead_rd;
          len_r      <= blen_rd;
          idx        <= '0;
        end
        mrh_pkg::OP_WALK:   idx <= idx + CW'(1);
        mrh_pkg::OP_WALK_W: ptr <= link_rd;
        mrh_pkg::OP_REP:    idx <= idx_dec;
        mrh_pkg::OP_REP_S:  slot <= scr_rd;
        mrh_pkg::OP_REP_K: begin
          bsel  <= key_span(ekey_rd ^ last_key);
          key_r <= ekey_rd;
        end
        mrh_pkg::OP_REP_B: used[bsel] <= 1'b1;
        mrh_pkg::OP_POP_RD: bsel <= '0;
        mrh_pkg::OP_POP_B: begin
          slot  <= bhead_rd;
          len_r <= blen_rd;
        end
        mrh_pkg::OP_POP_E: begin
          if (len_dec == '0) used[0] <= 1'b0;
          cnt       <= cnt - CW'(1);
          status    <= mrh_pkg::ST_OK;
          out_key   <= ekey_rd;
          out_value <= eval_rd;
          count     <= cnt - CW'(1);
          is_empty  <= (cnt == CW'(1));
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/monotone_radix_heap.sv
// The result registers once the item's states are done: a push passes load, check, read and
// write; an error item load, check and error; a pop from a nonempty bucket 0 load, check,
// read, head and emit. A pop that refiles bucket b walks its links, then refiles each entry
// (one registered read port per memory). One item in flight; the next item is accepted the
// cycle after its result registers, even while that result waits.
// rst (synchronous) empties the heap: no clearing pass, free list tracked by a high-water mark.
module monotone_radix_heap #(
  parameter int CAPACITY   = mrh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = mrh_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = mrh_pkg::VALUE_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  opcode,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [CW-1:0]         count,
  output logic                  is_empty
);

  mrh_pkg::cmd_t  cmd;
  mrh_pkg::stat_t st;

  mrh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mrh_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .opcode    (opcode),
    .key       (key),
    .value     (value),
    .status    (status),
    .out_key   (out_key),
    .out_value (out_value),
    .count     (count),
    .is_empty  (is_empty)
  );

endmodule

FILE: tb/sv/tb_monotone_radix_heap.sv
module tb_monotone_radix_heap;

  localparam int NSLOT = 1024;
  localparam int NBKT = 33;
  localparam logic OPC_PUSH = 1'b0;
  localparam logic OPC_POP = 1'b1;
  localparam int STALL_LIMIT = 50000;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] key;
    logic [31:0] value;
    logic [10:0] count;
    logic is_empty;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OPC_PUSH;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [31:0] out_key;
  logic [31:0] out_value;
  logic [10:0] count;
  logic is_empty;

  always #1 clk = ~clk;

  monotone_radix_heap u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .key(key), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_key(out_key), .out_value(out_value),
    .count(count), .is_empty(is_empty)
  );

  // shadow heap
  logic [31:0] h_key [NSLOT];
  logic [31:0] h_val [NSLOT];
  int unsigned h_link [NSLOT];
  int unsigned h_free [NSLOT];
  int unsigned b_head [NBKT];
  logic [31:0] b_min [NBKT];
  bit b_used [NBKT];
  int unsigned b_len [NBKT];
  logic [31:0] last_key;
  int unsigned held;

  heap_res_t expected_q [$];
  int errors = 0;
  int in_idle = 0;
  int out_idle = 0;
  int hold_cycles = 0;
  int quiet = 0;

  function automatic int unsigned msb_pos(logic [31:0] x);
    int unsigned n;
    n = 0;
    while (x != 0) begin
      n++;
      x = x >> 1;
    end
    return n;
  endfunction

  function automatic void bucket_clear(int unsigned b);
    b_used[b] = 1'b0;
    b_min[b] = '1;
    b_len[b] = 0;
  endfunction

  function automatic void bucket_insert(int unsigned s);
    int unsigned b;
    b = msb_pos(h_key[s] ^ last_key);
    if (!b_used[b] || h_key[s] < b_min[b]) b_min[b] = h_key[s];
    h_link[s] = b_head[b];
    b_head[b] = s;
    b_len[b]++;
    b_used[b] = 1'b1;
  endfunction

  function automatic heap_res_t heap_apply(logic op, logic [31:0] k, logic [31:0] v);
    heap_res_t r;
    int unsigned s, b, n, p;
    int unsigned walk [$];
    r = '0;
    if (op == OPC_PUSH) begin
      if (held >= NSLOT) r.status = mrh_pkg::ST_FULL;
      else if (k < last_key) r.status = mrh_pkg::ST_LOW;
      else begin
        s = h_free[NSLOT - 1 - held];
        h_key[s] = k;
        h_val[s] = v;
        held++;
        bucket_insert(s);
      end
    end else if (held == 0) begin
      r.status = mrh_pkg::ST_EMPTY;
    end else begin
      if (!b_used[0]) begin
        b = 1;
        while (b < NBKT - 1 && !b_used[b]) b++;
        last_key = b_min[b];
        n = b_len[b];
        p = b_head[b];
        walk = {};
        for (int i = 0; i < n; i++) begin
          walk.insert(walk.size(), p);
          p = h_link[p];
        end
        bucket_clear(b);
        for (int i = n - 1; i >= 0; i--) bucket_insert(walk[i]);
      end
      s = b_head[0];
      r.key = h_key[s];
      r.value = h_val[s];
      b_head[0] = h_link[s];
      b_len[0]--;
      if (b_len[0] == 0) bucket_clear(0);
      held--;
      h_free[NSLOT - 1 - held] = s;
    end
    r.count = held[10:0];
    r.is_empty = (held == 0);
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_item(logic op, logic [31:0] k, logic [31:0] v);
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (!in_ready);
    expected_q.insert(expected_q.size(), heap_apply(op, k, v));
    if ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle);
    end
  end

  always @(posedge clk) begin
    heap_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) report("result with nothing pending");
      else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (status !== e.status) report($sformatf("status %0d exp %0d", status, e.status));
        if (out_key !== e.key) report($sformatf("out_key %h exp %h", out_key, e.key));
        if (out_value !== e.value)
          report($sformatf("out_value %h exp %h", out_value, e.value));
        if (count !== e.count) report($sformatf("count %0d exp %0d", count, e.count));
        if (is_empty !== e.is_empty) report($sformatf("is_empty %b exp %b", is_empty, e.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    logic [31:0] off, k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 5 && last_key != 0) return $urandom_range(0, last_key - 1);
    if (sel < 10) return '1;
    if (sel < 25) return last_key;
    off = $urandom() >> $urandom_range(0, 31);
    k = last_key + off;
    if (k < last_key) k = '1;
    return k;
  endfunction

  task automatic run_random(int n, int pop_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < pop_pct) send_item(OPC_POP, $urandom(), $urandom());
      else send_item(OPC_PUSH, pick_key(), $urandom());
    end
  endtask

  task automatic test_directed();
    send_item(OPC_POP, '1, '1);
    send_item(OPC_PUSH, 32'd0, 32'd0);
    send_item(OPC_PUSH, 32'd0, '1);
    send_item(OPC_PUSH, '1, 32'hA5A5_5A5A);
    send_item(OPC_PUSH, 32'h8000_0000, 32'h1);
    send_item(OPC_PUSH, 32'h0000_0001, 32'h2);
    send_item(OPC_PUSH, 32'h0000_0010, 32'h3);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_PUSH, 32'd0, 32'h4);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_PUSH, 32'h8000_0001, 32'h5);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_POP, '0, '0);
    send_item(OPC_POP, '0, '0);
  endtask

  task automatic test_full();
    while (held < NSLOT) send_item(OPC_PUSH, pick_key(), $urandom());
    send_item(OPC_PUSH, '1, '1);
    send_item(OPC_PUSH, last_key, 32'h77);
  endtask

  task automatic test_phases();
    in_idle = 0;  out_idle = 0;  run_random(50, 60);
    in_idle = 63; out_idle = 0;  run_random(50, 60);
    in_idle = 0;  out_idle = 63; run_random(50, 60);
    in_idle = 32; out_idle = 32; run_random(50, 60);
  endtask

  task automatic test_pressure();
    in_idle = 0;
    out_idle = 0;
    hold_cycles = 300;
    run_random(12, 50);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    run_random(20, 50);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      h_key[i] = '0;
      h_val[i] = '0;
      h_link[i] = 0;
      h_free[i] = i;
    end
    for (int b = 0; b < NBKT; b++) begin
      b_head[b] = 0;
      bucket_clear(b);
    end
    last_key = '0;
    held = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full();
    test_phases();
    test_pressure();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
